// ===== sv/sit_pkg.sv =====
// shared types, widths and codes for the sampled index table
package sit_pkg;

  // fixed field widths
  localparam int SIT_ELEM_W      = 32;
  localparam int SIT_POS_W       = 48;
  localparam int SIT_IDX_W       = 10;
  localparam int SIT_CMD_W       = 2;
  localparam int SIT_BITS_W      = 16;
  localparam int SIT_STATUS_W    = 2;
  localparam int SIT_CFG_IDX_W   = 2;
  localparam int SIT_MAX_SAMPLES = 1024;

  // request commands
  typedef enum logic [SIT_CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_NEXT   = 2'd2,
    CMD_CHECK  = 2'd3
  } sit_cmd_t;

  // result status codes
  typedef enum logic [SIT_STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_WRAP = 2'd1,
    ST_ERR  = 2'd2
  } sit_status_t;

  // configuration register indexes
  typedef enum logic [SIT_CFG_IDX_W-1:0] {
    REG_PAGE_MODE = 2'd0,
    REG_RATE      = 2'd1,
    REG_FIRST_POS = 2'd2
  } sit_cfg_reg_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_DIV,
    S_SRCH,
    S_SWAIT,
    S_NREAD,
    S_NWAIT,
    S_FETCH,
    S_FWAIT
  } sit_state_t;

  // strobes from the sequencer to the checkpoint store
  typedef struct packed {
    logic wr;
    logic rd_pos;
    logic rd_elem;
  } sit_store_ctl_t;

endpackage

// ===== sv/sampled_index_table.sv =====
// sampled index table top level: sequencer, config registers and result register
//
// Keeps a table of checkpoints (element number, file position) in two on-chip
// memories. Requests arrive on req_valid/req_stall with a command and its
// fields; one result per request leaves on res_valid/res_stall. Config is a
// plain write port (cfg_we, cfg_index, cfg_data) used while no request is open.
// One request is worked on at a time; req_stall is high from acceptance until
// the result is placed in the result register. Steps between decode and the
// final store read and result load:
//   add in page mode or to a full table, and check: none
//   add and lookup in regular mode: 32-step divide by the rate
//   lookup, page mode: binary search, one element read per search step
//   next: a read of the following element in page mode, unless it wraps
// A stalled result stays in the result register; a new request is still taken,
// and its result waits in the last step until the register frees up.
// Reset sets one checkpoint (element 0 at first_position), index 0, regular
// mode and rate 1. Memories are not cleared; only written entries are used.
module sampled_index_table import sit_pkg::*; #(
  parameter int MAX_SAMPLES = SIT_MAX_SAMPLES
) (
  input  logic                     clk,
  input  logic                     rst,
  // request channel
  input  logic                     req_valid,
  output logic                     req_stall,
  input  logic [SIT_CMD_W-1:0]     cmd,
  input  logic [SIT_ELEM_W-1:0]    elem_no,
  input  logic [SIT_POS_W-1:0]     position,
  input  logic [SIT_ELEM_W-1:0]    pages_done,
  input  logic [SIT_ELEM_W-1:0]    elems_done,
  input  logic [SIT_BITS_W-1:0]    elem_bits,
  input  logic [SIT_BITS_W-1:0]    free_bits,
  // result channel
  output logic                     res_valid,
  input  logic                     res_stall,
  output logic [SIT_STATUS_W-1:0]  status,
  output logic [SIT_IDX_W-1:0]     sample_index,
  output logic [SIT_ELEM_W-1:0]    sample_element,
  output logic [SIT_POS_W-1:0]     sample_position,
  output logic [SIT_ELEM_W-1:0]    next_element,
  output logic                     boundary_due,
  // config port
  input  logic                     cfg_we,
  input  logic [SIT_CFG_IDX_W-1:0] cfg_index,
  input  logic [SIT_POS_W-1:0]     cfg_data
);

  localparam int IW = $clog2(MAX_SAMPLES);
  localparam int CW = $clog2(MAX_SAMPLES + 1);

  // config registers
  logic                  page_mode;
  logic [SIT_ELEM_W-1:0] rate;
  logic [SIT_POS_W-1:0]  first_position;

  // table state
  sit_state_t            state, state_next;
  logic [CW-1:0]         sample_count, sample_count_next;
  logic [IW-1:0]         cur_index, cur_index_next;
  logic [SIT_ELEM_W-1:0] cur_elem, cur_elem_next;

  // search and per-request work registers
  logic [CW-1:0]         lo, lo_next, hi, hi_next, mid, mid_next;
  logic [SIT_ELEM_W-1:0] lo_elem, lo_elem_next;
  sit_status_t           op_status, op_status_next;
  logic                  op_due, op_due_next;

  // captured request
  sit_cmd_t              req_cmd;
  logic [SIT_ELEM_W-1:0] req_elem;
  logic [SIT_POS_W-1:0]  req_pos;
  logic [SIT_ELEM_W-1:0] req_pages;
  logic [SIT_ELEM_W-1:0] req_elems;
  logic [SIT_BITS_W-1:0] req_ebits;
  logic [SIT_BITS_W-1:0] req_fbits;

  // divider
  logic                  div_start;
  logic                  div_done;
  logic [SIT_ELEM_W-1:0] div_quo;
  logic [SIT_ELEM_W-1:0] div_rem;
  logic [SIT_ELEM_W-1:0] divisor;

  // store
  sit_store_ctl_t        st_ctl;
  logic [IW-1:0]         st_elem_addr;
  logic [SIT_POS_W-1:0]  pos_rd;
  logic [SIT_ELEM_W-1:0] elem_rd;

  // helpers
  logic [CW-1:0]         cur_succ;
  logic                  at_last;
  logic [CW-1:0]         span;
  logic [CW-1:0]         mid_calc;
  logic                  out_load;
  logic                  req_take;

  assign req_stall = (state != S_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign divisor   = (rate == '0) ? SIT_ELEM_W'(1) : rate;
  assign cur_succ  = CW'(cur_index) + CW'(1);
  assign at_last   = cur_succ >= sample_count;
  assign span      = hi - lo;
  assign mid_calc  = lo + (span >> 1);

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      page_mode      <= 1'b0;
      rate           <= SIT_ELEM_W'(1);
      first_position <= '0;
    end else if (cfg_we) begin
      case (sit_cfg_reg_t'(cfg_index))
        REG_PAGE_MODE: page_mode      <= cfg_data[0];
        REG_RATE:      rate           <= cfg_data[SIT_ELEM_W-1:0];
        REG_FIRST_POS: first_position <= cfg_data;
        default: ;
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (req_take) begin
      req_cmd   <= sit_cmd_t'(cmd);
      req_elem  <= elem_no;
      req_pos   <= position;
      req_pages <= pages_done;
      req_elems <= elems_done;
      req_ebits <= elem_bits;
      req_fbits <= free_bits;
    end
  end

  // sequencer: next state, table updates and strobes
  always_comb begin
    state_next        = state;
    sample_count_next = sample_count;
    cur_index_next    = cur_index;
    cur_elem_next     = cur_elem;
    lo_next           = lo;
    hi_next           = hi;
    mid_next          = mid;
    lo_elem_next      = lo_elem;
    op_status_next    = op_status;
    op_due_next       = op_due;
    div_start         = 1'b0;
    st_ctl            = '0;
    out_load          = 1'b0;
    st_elem_addr      = (state == S_SRCH) ? mid_calc[IW-1:0] : cur_succ[IW-1:0];

    case (state)
      S_IDLE: begin
        if (req_valid) begin
          op_status_next = ST_OK;
          op_due_next    = 1'b0;
          state_next     = S_DECODE;
        end
      end

      S_DECODE: begin
        case (req_cmd)
          CMD_ADD: begin
            if (sample_count >= CW'(MAX_SAMPLES)) begin
              op_status_next = ST_ERR;
              state_next     = S_FETCH;
            end else if (page_mode) begin
              st_ctl.wr         = 1'b1;
              sample_count_next = sample_count + CW'(1);
              state_next        = S_FETCH;
            end else begin
              div_start  = 1'b1;
              state_next = S_DIV;
            end
          end
          CMD_LOOKUP: begin
            if (page_mode) begin
              lo_next      = '0;
              hi_next      = sample_count;
              lo_elem_next = '0;
              state_next   = S_SRCH;
            end else begin
              div_start  = 1'b1;
              state_next = S_DIV;
            end
          end
          CMD_NEXT: begin
            if (at_last) begin
              cur_index_next = '0;
              cur_elem_next  = '0;
              op_status_next = ST_WRAP;
              state_next     = S_FETCH;
            end else if (page_mode) begin
              state_next = S_NREAD;
            end else begin
              cur_index_next = cur_index + IW'(1);
              cur_elem_next  = cur_elem + rate;
              state_next     = S_FETCH;
            end
          end
          CMD_CHECK: begin
            if (page_mode) begin
              op_due_next = (req_pages >= rate) && (req_fbits < req_ebits);
            end else begin
              op_due_next = req_elems >= rate;
            end
            state_next = S_FETCH;
          end
          default: state_next = S_FETCH;
        endcase
      end

      // add alignment test or regular lookup, once the quotient is ready
      S_DIV: begin
        if (div_done) begin
          if (req_cmd == CMD_ADD) begin
            if (div_rem != '0) begin
              op_status_next = ST_ERR;
            end else begin
              st_ctl.wr         = 1'b1;
              sample_count_next = sample_count + CW'(1);
            end
          end else begin
            if (div_quo >= SIT_ELEM_W'(sample_count)) begin
              op_status_next = ST_ERR;
            end else begin
              cur_index_next = div_quo[IW-1:0];
              cur_elem_next  = req_elem - div_rem;
            end
          end
          state_next = S_FETCH;
        end
      end

      // binary search for the last element at or below the request
      S_SRCH: begin
        if (span > CW'(1)) begin
          mid_next       = mid_calc;
          st_ctl.rd_elem = 1'b1;
          state_next     = S_SWAIT;
        end else begin
          cur_index_next = lo[IW-1:0];
          cur_elem_next  = lo_elem;
          state_next     = S_FETCH;
        end
      end

      S_SWAIT: begin
        if (elem_rd <= req_elem) begin
          lo_next      = mid;
          lo_elem_next = elem_rd;
        end else begin
          hi_next = mid;
        end
        state_next = S_SRCH;
      end

      // page-mode step: element of the following checkpoint
      S_NREAD: begin
        st_ctl.rd_elem = 1'b1;
        state_next     = S_NWAIT;
      end

      S_NWAIT: begin
        cur_index_next = cur_index + IW'(1);
        cur_elem_next  = elem_rd;
        state_next     = S_FETCH;
      end

      // read position of current and element of following checkpoint
      S_FETCH: begin
        st_ctl.rd_pos  = 1'b1;
        st_ctl.rd_elem = 1'b1;
        state_next     = S_FWAIT;
      end

      S_FWAIT: begin
        if (!res_valid || !res_stall) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // control and table state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sample_count <= CW'(1);
      cur_index    <= '0;
      cur_elem     <= '0;
    end else begin
      state        <= state_next;
      sample_count <= sample_count_next;
      cur_index    <= cur_index_next;
      cur_elem     <= cur_elem_next;
    end
  end

  // work registers
  always_ff @(posedge clk) begin
    lo        <= lo_next;
    hi        <= hi_next;
    mid       <= mid_next;
    lo_elem   <= lo_elem_next;
    op_status <= op_status_next;
    op_due    <= op_due_next;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status          <= op_status;
      sample_index    <= SIT_IDX_W'(cur_index);
      sample_element  <= cur_elem;
      sample_position <= (cur_index == '0) ? first_position : pos_rd;
      boundary_due    <= op_due;
      if (at_last) begin
        next_element <= '0;
      end else if (page_mode) begin
        next_element <= elem_rd;
      end else begin
        next_element <= cur_elem + rate;
      end
    end
  end

  // divider
  sit_div #(
    .W (SIT_ELEM_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (req_elem),
    .divisor   (divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // checkpoint memories
  sit_store #(
    .DEPTH (MAX_SAMPLES)
  ) u_store (
    .clk       (clk),
    .ctl       (st_ctl),
    .wr_addr   (sample_count[IW-1:0]),
    .wr_pos    (req_pos),
    .wr_elem   (req_elem),
    .pos_addr  (cur_index),
    .elem_addr (st_elem_addr),
    .pos_rd    (pos_rd),
    .elem_rd   (elem_rd)
  );

  // checkpoint count stays within the table
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (sample_count != '0) && (sample_count <= CW'(MAX_SAMPLES)))
    else $error("checkpoint count out of range");

  // current checkpoint is always a stored one
  a_index_valid: assert property (@(posedge clk) disable iff (rst)
    CW'(cur_index) < sample_count)
    else $error("current index beyond checkpoint count");

  // a divider result only arrives while the sequencer waits for it
  a_div_owned: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider result outside divide step");

  // a wrapped step always reports checkpoint zero
  a_wrap_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (status == ST_WRAP)) |-> (sample_index == '0) && (sample_element == '0))
    else $error("wrap result not at checkpoint zero");

endmodule

// ===== sv/sit_div.sv =====
// sequential restoring divider, one quotient bit per cycle
module sit_div import sit_pkg::*; #(
  parameter int W = SIT_ELEM_W
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);

  localparam int CNT_W = (W > 1) ? $clog2(W) : 1;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [W-1:0]     quo;
  logic [W-1:0]     rem;
  logic [W:0]       trial;
  logic [W:0]       diff;
  logic             fits;

  // shift in the next dividend bit and try the subtraction
  always_comb begin
    trial = {rem, quo[W-1]};
    diff  = trial - {1'b0, divisor};
    fits  = trial >= {1'b0, divisor};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= diff[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= trial[W-1:0];
        quo <= {quo[W-2:0], 1'b0};
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

// ===== sv/sit_store.sv =====
// checkpoint store: position and element memories, one write and one read port each
module sit_store import sit_pkg::*; #(
  parameter int DEPTH = SIT_MAX_SAMPLES
) (
  input  logic                     clk,
  input  sit_store_ctl_t           ctl,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [SIT_POS_W-1:0]     wr_pos,
  input  logic [SIT_ELEM_W-1:0]    wr_elem,
  input  logic [$clog2(DEPTH)-1:0] pos_addr,
  input  logic [$clog2(DEPTH)-1:0] elem_addr,
  output logic [SIT_POS_W-1:0]     pos_rd,
  output logic [SIT_ELEM_W-1:0]    elem_rd
);

  logic [SIT_POS_W-1:0]  pos_mem  [DEPTH];
  logic [SIT_ELEM_W-1:0] elem_mem [DEPTH];

  // position memory
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      pos_mem[wr_addr] <= wr_pos;
    end
    if (ctl.rd_pos) begin
      pos_rd <= pos_mem[pos_addr];
    end
  end

  // element memory
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      elem_mem[wr_addr] <= wr_elem;
    end
    if (ctl.rd_elem) begin
      elem_rd <= elem_mem[elem_addr];
    end
  end

endmodule

// ===== sim/sit_checker.sv =====
// checker for the sampled index table: watches both channels, predicts and compares results
`timescale 1ns / 100ps

module sit_checker import sit_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  // request channel
  input  logic                     req_valid,
  input  logic                     req_stall,
  input  logic [SIT_CMD_W-1:0]     cmd,
  input  logic [SIT_ELEM_W-1:0]    elem_no,
  input  logic [SIT_POS_W-1:0]     position,
  input  logic [SIT_ELEM_W-1:0]    pages_done,
  input  logic [SIT_ELEM_W-1:0]    elems_done,
  input  logic [SIT_BITS_W-1:0]    elem_bits,
  input  logic [SIT_BITS_W-1:0]    free_bits,
  // result channel
  input  logic                     res_valid,
  input  logic                     res_stall,
  input  logic [SIT_STATUS_W-1:0]  status,
  input  logic [SIT_IDX_W-1:0]     sample_index,
  input  logic [SIT_ELEM_W-1:0]    sample_element,
  input  logic [SIT_POS_W-1:0]     sample_position,
  input  logic [SIT_ELEM_W-1:0]    next_element,
  input  logic                     boundary_due,
  // config port
  input  logic                     cfg_we,
  input  logic [SIT_CFG_IDX_W-1:0] cfg_index,
  input  logic [SIT_POS_W-1:0]     cfg_data,
  // totals for the top
  output int                       fail_count,
  output int                       pending,
  output int                       checked,
  output int                       err_seen,
  output int                       wrap_seen,
  output int                       due_seen
);

  typedef struct {
    sit_status_t           st;
    logic [SIT_IDX_W-1:0]  idx;
    logic [SIT_ELEM_W-1:0] elem;
    logic [SIT_POS_W-1:0]  pos;
    logic [SIT_ELEM_W-1:0] nxt;
    logic                  due;
  } sample_result_t;

  // checkpoint table as the block should hold it
  logic [SIT_ELEM_W-1:0] elem_mem [SIT_MAX_SAMPLES];
  logic [SIT_POS_W-1:0]  pos_mem  [SIT_MAX_SAMPLES];
  int unsigned           n_samples = 1;
  int unsigned           cur = 0;
  logic [SIT_ELEM_W-1:0] cur_elem = '0;

  // register copies
  logic                  page_q = 1'b0;
  logic [SIT_ELEM_W-1:0] rate_q = 32'd1;
  logic [SIT_POS_W-1:0]  first_pos_q = '0;

  sample_result_t awaited_samples[$];
  int fails = 0;
  int n_checked = 0;
  int n_err = 0;
  int n_wrap = 0;
  int n_due = 0;

  // checkpoint zero is always element 0
  function automatic logic [SIT_ELEM_W-1:0] elem_of(input int unsigned i);
    return (i == 0) ? '0 : elem_mem[i];
  endfunction

  // apply one request to the table and return the result it should give
  function automatic sample_result_t sample_after_request(
    input sit_cmd_t              c,
    input logic [SIT_ELEM_W-1:0] el,
    input logic [SIT_POS_W-1:0]  pos,
    input logic [SIT_ELEM_W-1:0] pg,
    input logic [SIT_ELEM_W-1:0] ew,
    input logic [SIT_BITS_W-1:0] eb,
    input logic [SIT_BITS_W-1:0] fb
  );
    sample_result_t        r;
    logic [SIT_ELEM_W-1:0] eff;
    logic [SIT_ELEM_W-1:0] idx;
    int unsigned           lo;
    int unsigned           hi;
    int unsigned           mid;
    r.st  = ST_OK;
    r.due = 1'b0;
    // a zero rate divides as one
    eff = (rate_q == '0) ? 32'd1 : rate_q;
    case (c)
      CMD_ADD: begin
        if (n_samples >= SIT_MAX_SAMPLES || (!page_q && (el % eff) != 0)) begin
          r.st = ST_ERR;
        end else begin
          elem_mem[n_samples] = el;
          pos_mem[n_samples]  = pos;
          n_samples++;
        end
      end
      CMD_LOOKUP: begin
        if (!page_q) begin
          idx = el / eff;
          if (idx >= n_samples) begin
            r.st = ST_ERR;
          end else begin
            cur      = idx;
            cur_elem = idx * eff;
          end
        end else begin
          // last stored element at or below el, table taken as it stands
          lo = 0;
          hi = n_samples;
          while (hi - lo > 1) begin
            mid = lo + (hi - lo) / 2;
            if (elem_of(mid) <= el) lo = mid;
            else hi = mid;
          end
          cur      = lo;
          cur_elem = elem_of(lo);
        end
      end
      CMD_NEXT: begin
        if (cur + 1 >= n_samples) begin
          cur      = 0;
          cur_elem = '0;
          r.st     = ST_WRAP;
        end else begin
          cur++;
          cur_elem = page_q ? elem_of(cur) : cur_elem + rate_q;
        end
      end
      CMD_CHECK: begin
        r.due = page_q ? (pg >= rate_q && fb < eb) : (ew >= rate_q);
      end
      default: ;
    endcase
    r.idx  = cur[SIT_IDX_W-1:0];
    r.elem = cur_elem;
    r.pos  = (cur == 0) ? first_pos_q : pos_mem[cur];
    if (cur + 1 >= n_samples) r.nxt = '0;
    else if (page_q) r.nxt = elem_of(cur + 1);
    else r.nxt = cur_elem + rate_q;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (fails < 40) begin
      $display("%0t result %0d: %s got %h expected %h", $realtime, n_checked, what, got, want);
    end
    fails++;
  endtask

  sample_result_t exp_r;

  always @(posedge clk) begin
    if (rst) begin
      n_samples   = 1;
      cur         = 0;
      cur_elem    = '0;
      page_q      = 1'b0;
      rate_q      = 32'd1;
      first_pos_q = '0;
      awaited_samples.delete();
    end else begin
      // compare an accepted result with the oldest prediction
      if (res_valid && !res_stall) begin
        if (awaited_samples.size() == 0) begin
          report_mismatch("result with no request open, index", sample_index, '0);
        end else begin
          exp_r = awaited_samples.pop_front();
          if (status !== exp_r.st) report_mismatch("status", status, exp_r.st);
          if (sample_index !== exp_r.idx) report_mismatch("sample_index", sample_index, exp_r.idx);
          if (sample_element !== exp_r.elem) begin
            report_mismatch("sample_element", sample_element, exp_r.elem);
          end
          if (sample_position !== exp_r.pos) begin
            report_mismatch("sample_position", sample_position, exp_r.pos);
          end
          if (next_element !== exp_r.nxt) report_mismatch("next_element", next_element, exp_r.nxt);
          if (boundary_due !== exp_r.due) report_mismatch("boundary_due", boundary_due, exp_r.due);
          if (exp_r.st == ST_ERR) n_err++;
          if (exp_r.st == ST_WRAP) n_wrap++;
          if (exp_r.due) n_due++;
        end
        n_checked++;
      end
      // predict each accepted request
      if (req_valid && !req_stall) begin
        awaited_samples.push_back(sample_after_request(sit_cmd_t'(cmd), elem_no, position,
                                                       pages_done, elems_done,
                                                       elem_bits, free_bits));
      end
      // follow register writes
      if (cfg_we) begin
        case (sit_cfg_reg_t'(cfg_index))
          REG_PAGE_MODE: page_q      = cfg_data[0];
          REG_RATE:      rate_q      = cfg_data[SIT_ELEM_W-1:0];
          REG_FIRST_POS: first_pos_q = cfg_data;
          default: ;
        endcase
      end
    end
    fail_count <= fails;
    pending    <= awaited_samples.size();
    checked    <= n_checked;
    err_seen   <= n_err;
    wrap_seen  <= n_wrap;
    due_seen   <= n_due;
  end

endmodule

// ===== sim/tb_sampled_index_table.sv =====
// testbench top for the sampled index table: clock, reset, stimulus, idling and verdict
`timescale 1ns / 100ps

module tb_sampled_index_table;
  import sit_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     req_valid;
  logic                     req_stall;
  logic [SIT_CMD_W-1:0]     cmd;
  logic [SIT_ELEM_W-1:0]    elem_no;
  logic [SIT_POS_W-1:0]     position;
  logic [SIT_ELEM_W-1:0]    pages_done;
  logic [SIT_ELEM_W-1:0]    elems_done;
  logic [SIT_BITS_W-1:0]    elem_bits;
  logic [SIT_BITS_W-1:0]    free_bits;
  logic                     res_valid;
  logic                     res_stall;
  logic [SIT_STATUS_W-1:0]  status;
  logic [SIT_IDX_W-1:0]     sample_index;
  logic [SIT_ELEM_W-1:0]    sample_element;
  logic [SIT_POS_W-1:0]     sample_position;
  logic [SIT_ELEM_W-1:0]    next_element;
  logic                     boundary_due;
  logic                     cfg_we;
  logic [SIT_CFG_IDX_W-1:0] cfg_index;
  logic [SIT_POS_W-1:0]     cfg_data;

  int fail_count;
  int pending;
  int checked;
  int err_seen;
  int wrap_seen;
  int due_seen;

  // stimulus bookkeeping
  bit                    calm = 1'b0;
  logic                  cur_pm = 1'b0;
  logic [SIT_ELEM_W-1:0] cur_rate = 32'd1;
  logic [SIT_ELEM_W-1:0] last_page_elem = '0;
  int                    adds_landing = 0;
  int                    sent = 0;
  int                    n_settings = 0;
  int                    stall_hold = 0;
  int                    idle_run = 0;

  sampled_index_table i_dut (.*);

  sit_checker i_checker (.*);

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [SIT_POS_W-1:0] rand_pos();
    return {16'($urandom), $urandom};
  endfunction

  // result side back-pressure
  always @(posedge clk) begin
    if (stall_hold > 0) begin
      stall_hold--;
    end else if (calm) begin
      res_stall <= 1'b0;
    end else begin
      res_stall <= ($urandom_range(0, 2) == 0);
      stall_hold = gap_len();
    end
  end

  // one request: optional gap, then hold until accepted
  task automatic send_req(input sit_cmd_t c, input logic [SIT_ELEM_W-1:0] el,
                          input logic [SIT_POS_W-1:0] pos, input logic [SIT_ELEM_W-1:0] pg,
                          input logic [SIT_ELEM_W-1:0] ew, input logic [SIT_BITS_W-1:0] eb,
                          input logic [SIT_BITS_W-1:0] fb);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid  <= 1'b1;
    cmd        <= c;
    elem_no    <= el;
    position   <= pos;
    pages_done <= pg;
    elems_done <= ew;
    elem_bits  <= eb;
    free_bits  <= fb;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sent++;
  endtask

  // write all three registers once the block has drained
  task automatic configure(input logic pm, input logic [SIT_ELEM_W-1:0] rt,
                           input logic [SIT_POS_W-1:0] fp);
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_PAGE_MODE;
    cfg_data  <= {{(SIT_POS_W-1){1'b0}}, pm};
    @(posedge clk);
    cfg_index <= REG_RATE;
    cfg_data  <= {16'd0, rt};
    @(posedge clk);
    cfg_index <= REG_FIRST_POS;
    cfg_data  <= fp;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_pm   = pm;
    cur_rate = rt;
    n_settings++;
  endtask

  // random request, mostly shaped to land in the table
  task automatic rand_req(input int add_pct);
    sit_cmd_t              c;
    logic [SIT_ELEM_W-1:0] el;
    logic [SIT_POS_W-1:0]  pos;
    logic [SIT_ELEM_W-1:0] pg;
    logic [SIT_ELEM_W-1:0] ew;
    logic [SIT_BITS_W-1:0] eb;
    logic [SIT_BITS_W-1:0] fb;
    logic [SIT_ELEM_W-1:0] eff;
    logic [63:0]           k;
    logic [63:0]           wide;
    int                    r;
    eff = (cur_rate == '0) ? 32'd1 : cur_rate;
    el  = $urandom;
    pos = rand_pos();
    pg  = $urandom;
    ew  = $urandom;
    eb  = 16'($urandom);
    fb  = 16'($urandom);
    r   = $urandom_range(0, 99);
    if (r < add_pct) begin
      c = CMD_ADD;
    end else begin
      r = $urandom_range(0, 99);
      c = (r < 45) ? CMD_LOOKUP : (r < 75) ? CMD_NEXT : CMD_CHECK;
    end
    case (c)
      CMD_ADD: begin
        if (cur_pm) begin
          // ascending element numbers, now and then one out of order
          if ($urandom_range(0, 9) != 0) begin
            wide = {32'd0, last_page_elem} + $urandom_range(1, 3000);
            if (wide > 64'hFFFF_FFFF) wide = $urandom_range(0, 3000);
            el = wide[31:0];
            last_page_elem = el;
          end
          adds_landing++;
        end else if ($urandom_range(0, 6) != 0) begin
          // aligned to the rate
          wide = 64'hFFFF_FFFF / eff;
          if ($urandom_range(0, 3) == 0 || wide <= 3000) k = $urandom_range(0, wide[31:0]);
          else k = $urandom_range(0, 3000);
          wide = k * eff;
          el = wide[31:0];
          adds_landing++;
        end
      end
      CMD_LOOKUP: begin
        if (cur_pm) begin
          if ($urandom_range(0, 4) != 0 && last_page_elem < 32'hFFFF_FF00) begin
            el = $urandom_range(0, last_page_elem + 200);
          end
        end else if ($urandom_range(0, 3) != 0) begin
          // an index the table probably holds
          k = $urandom_range(0, adds_landing);
          wide = k * eff + $urandom_range(0, eff - 1);
          if (wide <= 64'hFFFF_FFFF) el = wide[31:0];
        end
      end
      CMD_CHECK: begin
        if ($urandom_range(0, 1) == 0) begin
          pg = cur_rate + $urandom_range(0, 2) - 1;
          ew = cur_rate + $urandom_range(0, 2) - 1;
        end
        if ($urandom_range(0, 7) == 0) fb = eb;
      end
      default: ;
    endcase
    send_req(c, el, pos, pg, ew, eb, fb);
  endtask

  task automatic run_phase(input logic pm, input logic [SIT_ELEM_W-1:0] rt,
                           input logic [SIT_POS_W-1:0] fp, input int n, input int add_pct,
                           input bit quiet);
    configure(pm, rt, fp);
    calm = quiet;
    repeat (n) rand_req(add_pct);
  endtask

  // watchdog on cycles with no request or result accepted
  initial begin
    while (idle_run < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (res_valid && !res_stall)) idle_run = 0;
      else idle_run++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst        <= 1'b1;
    req_valid  <= 1'b0;
    cmd        <= CMD_ADD;
    elem_no    <= '0;
    position   <= '0;
    pages_done <= '0;
    elems_done <= '0;
    elem_bits  <= '0;
    free_bits  <= '0;
    res_stall  <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_index  <= REG_PAGE_MODE;
    cfg_data   <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: regular mode, rate 1, top position
    configure(1'b0, 32'd1, 48'hFFFF_FFFF_FFFF);
    // only checkpoint zero: next wraps, lookups past it fail
    send_req(CMD_NEXT, '0, '0, '0, '0, '0, '0);
    send_req(CMD_LOOKUP, '0, '0, '0, '0, '0, '0);
    send_req(CMD_LOOKUP, 32'd1, '0, '0, '0, '0, '0);
    send_req(CMD_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0, '0, '0);
    send_req(CMD_CHECK, '0, '0, '0, '0, '0, '0);
    send_req(CMD_CHECK, '0, '0, '0, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    send_req(CMD_ADD, 32'd1, 48'hFFFF_FFFF_FFFF, '0, '0, '0, '0);
    send_req(CMD_ADD, 32'd2, '0, '0, '0, '0, '0);
    send_req(CMD_NEXT, '0, '0, '0, '0, '0, '0);
    send_req(CMD_NEXT, '0, '0, '0, '0, '0, '0);
    send_req(CMD_NEXT, '0, '0, '0, '0, '0, '0);
    send_req(CMD_LOOKUP, 32'd2, '0, '0, '0, '0, '0);
    // rate 4: unaligned add fails, aligned one lands
    configure(1'b0, 32'd4, '0);
    send_req(CMD_ADD, 32'd5, rand_pos(), '0, '0, '0, '0);
    send_req(CMD_ADD, 32'd12, rand_pos(), '0, '0, '0, '0);
    send_req(CMD_LOOKUP, 32'd15, '0, '0, '0, '0, '0);
    send_req(CMD_LOOKUP, 32'd16, '0, '0, '0, '0, '0);
    // page mode over the stored elements, top element and check extremes
    configure(1'b1, 32'd3, 48'h1234_5678_9ABC);
    send_req(CMD_ADD, 32'hFFFF_FFFF, rand_pos(), '0, '0, '0, '0);
    send_req(CMD_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0, '0, '0);
    send_req(CMD_LOOKUP, 32'd11, '0, '0, '0, '0, '0);
    send_req(CMD_LOOKUP, '0, '0, '0, '0, '0, '0);
    send_req(CMD_NEXT, '0, '0, '0, '0, '0, '0);
    send_req(CMD_CHECK, '0, '0, 32'd3, '0, 16'hFFFF, '0);
    send_req(CMD_CHECK, '0, '0, 32'd2, '0, 16'hFFFF, '0);
    send_req(CMD_CHECK, '0, '0, 32'hFFFF_FFFF, '0, '0, 16'hFFFF);
    adds_landing = 4;

    // random phases across modes and rates, zero rate and extremes among them
    run_phase(1'b0, 32'd1, rand_pos(), 100, 65, 1'b1);
    run_phase(1'b0, $urandom_range(2, 16), 48'hFFFF_FFFF_FFFF, 100, 65, 1'b0);
    run_phase(1'b1, $urandom_range(1, 8), rand_pos(), 150, 65, 1'b0);
    run_phase(1'b0, 32'd0, rand_pos(), 60, 60, 1'b0);
    run_phase(1'b1, 32'hFFFF_FFFF, '0, 80, 60, 1'b0);
    run_phase(1'b0, 32'hFFFF_FFFF, rand_pos(), 50, 60, 1'b0);
    run_phase(1'b0, $urandom, rand_pos(), 60, 60, 1'b0);
    run_phase(1'b1, 32'd0, rand_pos(), 40, 60, 1'b0);

    // fill the table past full so that adds start to fail
    configure(1'b1, $urandom_range(1, 4), rand_pos());
    calm = 1'b0;
    while (adds_landing < SIT_MAX_SAMPLES + 8) rand_req(90);

    // full table in both modes
    run_phase(1'b0, 32'd1, rand_pos(), 40, 20, 1'b0);
    run_phase(1'b1, $urandom_range(1, 8), rand_pos(), 40, 20, 1'b1);

    // drain
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("covered %0d requests over %0d register settings, %0d results compared",
             sent, n_settings, checked);
    $display("results seen: %0d errors, %0d wraps, %0d checks with a checkpoint due",
             err_seen, wrap_seen, due_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/sit_pkg.sv
sv/sit_div.sv
sv/sit_store.sv
sv/sampled_index_table.sv
sim/sit_checker.sv
sim/tb_sampled_index_table.sv
